@@ hdl/bb3_pkg.sv @@
package bb3_pkg;

  // line geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int COL_BITS   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WID_BITS   = $clog2(MAX_WIDTH + 1);
  localparam int FILL_BITS  = $clog2(MAX_WIDTH + 2);
  localparam int ROW_BITS   = 12;

  // configuration register widths and reset values
  localparam int FW_BITS = 11;
  localparam int FH_BITS = 12;
  localparam logic [FW_BITS-1:0] FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RESET = 12'd480;

  // apb register map, one register every 4 bytes
  localparam int ADDR_BITS    = 3;
  localparam int ADDR_IDX_BIT = 2;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // stream commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // pixel data
  localparam int CH_BITS   = 8;
  localparam int PIX_BITS  = 3 * CH_BITS;
  localparam int LINE_BITS = 2 * PIX_BITS;

  // mean arithmetic: sum of up to nine taps plus half divisor
  localparam int SUM_BITS    = 12;
  localparam int DIV_BITS    = 4;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_BITS  = RECIP_SHIFT + 1;
  localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

  localparam logic [RECIP_BITS-1:0] RECIP_1 = RECIP_BITS'(2 ** RECIP_SHIFT);
  localparam logic [RECIP_BITS-1:0] RECIP_2 = RECIP_BITS'((2 ** RECIP_SHIFT) / 2);
  localparam logic [RECIP_BITS-1:0] RECIP_3 = RECIP_BITS'((2 ** RECIP_SHIFT + 2) / 3);
  localparam logic [RECIP_BITS-1:0] RECIP_4 = RECIP_BITS'((2 ** RECIP_SHIFT) / 4);
  localparam logic [RECIP_BITS-1:0] RECIP_6 = RECIP_BITS'((2 ** RECIP_SHIFT + 5) / 6);
  localparam logic [RECIP_BITS-1:0] RECIP_9 = RECIP_BITS'((2 ** RECIP_SHIFT + 8) / 9);

  typedef struct packed {
    logic               cmd;
    logic [CH_BITS-1:0] red_in;
    logic [CH_BITS-1:0] green_in;
    logic [CH_BITS-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [CH_BITS-1:0] red_out;
    logic [CH_BITS-1:0] green_out;
    logic [CH_BITS-1:0] blue_out;
    logic               frame_end;
  } pix_out_t;

  // line store port controls
  typedef struct packed {
    logic                rd_en;
    logic [COL_BITS-1:0] rd_addr;
    logic                wr_en;
    logic [COL_BITS-1:0] wr_addr;
  } ls_ctrl_t;

  // fixed point reciprocal of a divisor, exact for sums below 2^15
  function automatic logic [RECIP_BITS-1:0] bb3_recip(input logic [DIV_BITS-1:0] n);
    logic [RECIP_BITS-1:0] k;
    case (n)
      4'd1:    k = RECIP_1;
      4'd2:    k = RECIP_2;
      4'd3:    k = RECIP_3;
      4'd4:    k = RECIP_4;
      4'd6:    k = RECIP_6;
      4'd9:    k = RECIP_9;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

@@ hdl/bb3_line_store.sv @@
module bb3_line_store (
  input  logic                          clk,
  input  logic                          rst,
  input  bb3_pkg::ls_ctrl_t             ctrl,
  input  logic [bb3_pkg::LINE_BITS-1:0] wr_data,
  output logic [bb3_pkg::LINE_BITS-1:0] rd_data
);

  // each entry holds {upper line pixel, lower line pixel} of one column
  logic [bb3_pkg::LINE_BITS-1:0] mem [bb3_pkg::MAX_WIDTH];
  logic [bb3_pkg::LINE_BITS-1:0] rd_q;
  logic [bb3_pkg::LINE_BITS-1:0] byp_data;
  logic                          byp;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_q     <= mem[ctrl.rd_addr];
      byp_data <= wr_data;
    end
  end

  // read of the entry being written in the same cycle takes the new data
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (ctrl.rd_en) begin
      byp <= ctrl.wr_en && (ctrl.wr_addr == ctrl.rd_addr);
    end
  end

  assign rd_data = byp ? byp_data : rd_q;

endmodule

@@ hdl/box_blur_3x3_rgb_unit.sv @@
// 3x3 box blur with edge clipping for an RGB pixel stream in raster order. One transaction is
// accepted every clock while the output is not stalled; each result is the half-up rounded mean
// of the in-frame taps of its 3x3 neighbourhood, per channel, and is valid once the transaction
// completing it has passed the three pipeline registers. Results lag the pixels by one line
// plus one pixel, so after the last pixel of a frame the source sends frame_width + 1 drain
// transactions (cmd = 1) to flush the final results; the last result carries frame_end. The
// rate is set by the line memory, one read and one write port per cycle, and by three pipeline
// registers (memory read, tap sums, reciprocal multiply) that each hold one transaction, so while
// a result waits the input keeps flowing until two more results are held behind it.
// Pixels past the end of a frame and early drains are taken and dropped. Writing frame_width
// or frame_height over the APB port restarts the frame; the line memory comes up unwritten and
// needs no clearing pass.
module box_blur_3x3_rgb_unit (
  input  logic                          clk,
  input  logic                          rst,
  // apb configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bb3_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // pixel stream
  input  logic                          pixel_valid,
  output logic                          pixel_ready,
  input  bb3_pkg::pix_in_t              pixel,
  // blurred stream
  output logic                          result_valid,
  input  logic                          result_ready,
  output bb3_pkg::pix_out_t             result
);

  localparam int CB = bb3_pkg::COL_BITS;
  localparam int WB = bb3_pkg::WID_BITS;
  localparam int FB = bb3_pkg::FILL_BITS;
  localparam int RB = bb3_pkg::ROW_BITS;
  localparam int PB = bb3_pkg::PIX_BITS;
  localparam int SB = bb3_pkg::SUM_BITS;
  localparam int DB = bb3_pkg::DIV_BITS;

  // configuration registers
  logic [bb3_pkg::FW_BITS-1:0] frame_width;
  logic [bb3_pkg::FH_BITS-1:0] frame_height;
  logic                        cfg_wr;
  logic [WB-1:0]               eff_w;
  logic [RB-1:0]               eff_h;

  // input side position and output side position, all tracked at accept time
  logic [CB-1:0] in_column;
  logic [RB-1:0] in_row;
  logic [CB-1:0] out_col;
  logic [RB-1:0] out_row;
  logic [FB-1:0] fill;

  logic [CB-1:0] col_cur;
  logic [CB-1:0] col_next;
  logic [WB-1:0] col_inc;
  logic          col_wrap;
  logic          step_pix;
  logic          step_drain;
  logic          step;
  logic          accept;
  logic          emit;
  logic          last_col;
  logic          last_row;
  logic          frame_done;
  logic          use_left;
  logic          use_right;
  logic          use_top;
  logic          use_bot;

  // stage 1: line memory read data plus tap flags
  logic          s1_valid;
  logic          s1_fresh;
  logic          s1_pix;
  logic [PB-1:0] s1_px;
  logic [CB-1:0] s1_addr;
  logic          s1_emit;
  logic          s1_left;
  logic          s1_right;
  logic          s1_top;
  logic          s1_bot;
  logic          s1_end;

  // stage 2: rounded sums and divisor
  logic          s2_valid;
  logic [SB-1:0] s2_x [3];
  logic [DB-1:0] s2_n;
  logic          s2_end;

  logic          s2_free;
  logic          out_adv;

  bb3_pkg::ls_ctrl_t              ls_ctrl;
  logic [bb3_pkg::LINE_BITS-1:0] ls_rd;
  logic [bb3_pkg::LINE_BITS-1:0] ls_wr;

  logic [PB-1:0] win [6];
  logic [PB-1:0] col_px [3];
  logic [SB-1:0] s1_x [3];
  logic [DB-1:0] s1_n;
  logic [1:0]    ncol;
  logic [1:0]    nrow;

  logic [bb3_pkg::RECIP_BITS-1:0] recip;
  logic [bb3_pkg::PROD_BITS-1:0]  prod [3];
  bb3_pkg::pix_out_t              res_next;

  // ---------------------------------------------------------------------------------------
  // apb port: never inserts wait states, index taken from one address bit
  // ---------------------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[bb3_pkg::ADDR_IDX_BIT])
      bb3_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      bb3_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height);
    endcase
  end

  // zero size counts as one, widths past the line memory clip to it
  always_comb begin
    if (frame_width == '0) begin
      eff_w = WB'(1);
    end else if (32'(frame_width) > 32'(bb3_pkg::MAX_WIDTH)) begin
      eff_w = WB'(bb3_pkg::MAX_WIDTH);
    end else begin
      eff_w = WB'(frame_width);
    end
    eff_h = (frame_height == '0) ? RB'(1) : frame_height;
  end

  // ---------------------------------------------------------------------------------------
  // handshake: each stage moves when the one after it is free or leaving
  // ---------------------------------------------------------------------------------------
  assign out_adv     = !result_valid || result_ready;
  assign s2_free     = !s2_valid || out_adv;
  assign pixel_ready = !s1_valid || !s1_emit || s2_free;
  assign accept      = pixel_valid && pixel_ready;

  // ---------------------------------------------------------------------------------------
  // accept time control: position, fill and tap flags for this transaction
  // ---------------------------------------------------------------------------------------
  always_comb begin
    col_cur    = (WB'(in_column) >= eff_w) ? '0 : in_column;
    col_inc    = WB'(col_cur) + WB'(1);
    col_wrap   = (col_inc >= eff_w);
    col_next   = col_wrap ? '0 : CB'(col_inc);
    // pixels past the frame and drains before its end are dropped
    step_pix   = (pixel.cmd == bb3_pkg::CMD_PIXEL) && (in_row < eff_h);
    step_drain = (pixel.cmd == bb3_pkg::CMD_DRAIN) && (in_row >= eff_h);
    step       = step_pix || step_drain;
    emit       = (fill >= (FB'(eff_w) + FB'(1)));
    last_col   = ((WB'(out_col) + WB'(1)) >= eff_w);
    last_row   = (({1'b0, out_row} + (RB+1)'(1)) >= {1'b0, eff_h});
    frame_done = emit && last_col && last_row;
    use_left   = (out_col != '0);
    use_right  = !last_col;
    use_top    = (out_row != '0);
    use_bot    = !last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bb3_pkg::FRAME_WIDTH_RESET;
      frame_height <= bb3_pkg::FRAME_HEIGHT_RESET;
      in_column    <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
      fill         <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[bb3_pkg::ADDR_IDX_BIT])
        bb3_pkg::REG_FRAME_WIDTH:  frame_width  <= pwdata[bb3_pkg::FW_BITS-1:0];
        bb3_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[bb3_pkg::FH_BITS-1:0];
      endcase
      in_column <= '0;
      in_row    <= '0;
      out_col   <= '0;
      out_row   <= '0;
      fill      <= '0;
    end else if (accept && step) begin
      if (frame_done) begin
        // last result of the frame: next pixel starts a new frame
        in_column <= '0;
        in_row    <= '0;
        out_col   <= '0;
        out_row   <= '0;
        fill      <= '0;
      end else begin
        in_column <= col_next;
        if (step_pix && col_wrap) begin
          in_row <= in_row + RB'(1);
        end
        if (!emit) begin
          fill <= fill + FB'(1);
        end else if (last_col) begin
          out_col <= '0;
          out_row <= out_row + RB'(1);
        end else begin
          out_col <= out_col + CB'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // line memory: read at accept, write back in the next cycle
  // ---------------------------------------------------------------------------------------
  always_comb begin
    ls_ctrl.rd_en   = accept && step;
    ls_ctrl.rd_addr = col_cur;
    ls_ctrl.wr_en   = s1_fresh && s1_pix;
    ls_ctrl.wr_addr = s1_addr;
    // lower line moves up, new pixel becomes the lower line
    ls_wr = {ls_rd[PB-1:0], s1_px};
  end

  bb3_line_store u_line_store (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ls_ctrl),
    .wr_data (ls_wr),
    .rd_data (ls_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fresh <= 1'b0;
    end else begin
      s1_fresh <= accept && step;
      if (pixel_ready) begin
        s1_valid <= accept && step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && step) begin
      s1_pix   <= step_pix;
      s1_px    <= {pixel.red_in, pixel.green_in, pixel.blue_in};
      s1_addr  <= col_cur;
      s1_emit  <= emit;
      s1_left  <= use_left;
      s1_right <= use_right;
      s1_top   <= use_top;
      s1_bot   <= use_bot;
      s1_end   <= frame_done;
    end
  end

  // ---------------------------------------------------------------------------------------
  // stage 1: clipped tap sums over window columns and the new column
  // ---------------------------------------------------------------------------------------
  always_comb begin
    col_px[0] = ls_rd[bb3_pkg::LINE_BITS-1:PB];
    col_px[1] = ls_rd[PB-1:0];
    col_px[2] = s1_pix ? s1_px : '0;
    ncol      = 2'd1 + 2'(s1_left) + 2'(s1_right);
    nrow      = 2'd1 + 2'(s1_top) + 2'(s1_bot);
    s1_n      = DB'(ncol) * DB'(nrow);
    for (int k = 0; k < 3; k++) begin
      s1_x[k] = SB'(s1_n >> 1);
      for (int r = 0; r < 3; r++) begin
        if (!((r == 0 && !s1_top) || (r == 2 && !s1_bot))) begin
          if (s1_left) begin
            s1_x[k] = s1_x[k] + SB'(win[r][(2-k)*bb3_pkg::CH_BITS +: bb3_pkg::CH_BITS]);
          end
          s1_x[k] = s1_x[k] + SB'(win[3+r][(2-k)*bb3_pkg::CH_BITS +: bb3_pkg::CH_BITS]);
          if (s1_right) begin
            s1_x[k] = s1_x[k] + SB'(col_px[r][(2-k)*bb3_pkg::CH_BITS +: bb3_pkg::CH_BITS]);
          end
        end
      end
    end
  end

  // window shifts once per completed step, whether or not it gave a result
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_valid && pixel_ready) begin
      for (int r = 0; r < 3; r++) begin
        win[r]   <= win[3+r];
        win[3+r] <= col_px[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_x   <= s1_x;
      s2_n   <= s1_n;
      s2_end <= s1_end;
    end
  end

  // ---------------------------------------------------------------------------------------
  // stage 2: divide by reciprocal multiply into the result register
  // ---------------------------------------------------------------------------------------
  always_comb begin
    recip = bb3_pkg::bb3_recip(s2_n);
    for (int k = 0; k < 3; k++) begin
      prod[k] = bb3_pkg::PROD_BITS'(s2_x[k]) * bb3_pkg::PROD_BITS'(recip);
    end
    res_next.red_out   = prod[0][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_BITS];
    res_next.green_out = prod[1][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_BITS];
    res_next.blue_out  = prod[2][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_BITS];
    res_next.frame_end = s2_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_adv) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      result <= res_next;
    end
  end

  // ---------------------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------------------
  a_fresh_valid: assert property (@(posedge clk) disable iff (rst) s1_fresh |-> s1_valid)
    else $error("memory write-back without a stage 1 transaction");

  a_divisor: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (s2_n == 4'd1 || s2_n == 4'd2 || s2_n == 4'd3 ||
                  s2_n == 4'd4 || s2_n == 4'd6 || s2_n == 4'd9))
    else $error("divisor outside the clipped window set");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (WB'(in_column) < eff_w) && (WB'(out_col) < eff_w))
    else $error("column position past the frame width");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= (FB'(eff_w) + FB'(1)))
    else $error("fill count past its saturation point");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && step && frame_done && !cfg_wr) |=> (fill == '0 && in_row == '0))
    else $error("frame end did not restart the counters");

endmodule
